// ----- rtl/stereo_log_envelope_follower_top_macros.svh -----
// Assertion macros shared by the envelope follower RTL.
`ifndef STEREO_LOG_ENVELOPE_FOLLOWER_TOP_MACROS_SVH
`define STEREO_LOG_ENVELOPE_FOLLOWER_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, quiet while rst_n is low.
`define SLEF_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked on clk, quiet while rst_n is low.
`define SLEF_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/slef_pkg.sv -----
// Shared constants for the stereo log envelope follower.
`default_nettype none
package slef_pkg;
  localparam int MAX_BUFFER_DEF = 128;
  localparam int LEVEL_FRAC_DEF = 16;

  localparam int SAMPLE_W = 32;
  localparam int COEF_W   = 17;
  localparam int OUT_W    = 23;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 1'b1;

  localparam logic signed [COEF_W-1:0] ATTACK_RST  = -17'sd6554;
  localparam logic signed [COEF_W-1:0] RELEASE_RST = -17'sd655;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [31:0] LN2_Q30 = 32'd744261118;
  localparam logic signed [OUT_W-1:0] LN_FLOOR = -23'sd3621653;

  localparam int EXP_TERMS = 14;
  localparam int LOG_BITS  = 20;
endpackage
`default_nettype wire

// ----- rtl/slef_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module slef_div #(
  parameter int NW = 56,
  parameter int DW = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);
  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   sh_r, sh_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   den_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DW:0]     trial;

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, sh_r[NW-1]};
    if (start) begin
      sh_nxt   = num;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DW'(trial - {1'b0, den_r});
        sh_nxt  = {sh_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        sh_nxt  = {sh_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = sh_r;
endmodule
`default_nettype wire

// ----- rtl/stereo_log_envelope_follower_top.sv -----
// Top level of the stereo log envelope follower.
`default_nettype none
// Stereo envelope follower: sums |sample| per channel over a buffer, and on
// the beat flagged by in_tlast updates each channel's level toward the
// buffer mean with an attack or release time constant, then emits ln(level)
// in Q.16 per channel. A closing beat keeps in_tready low while both
// channels are worked and the result is loaded; the work grows with i, the
// integer part of -coef * n (fewer steps once the gain reaches zero), and
// falls as p, the top set bit of the new level, rises. A channel whose new
// level is zero skips the log. The bit-serial divider runs 29 times per
// channel (one mean division, 28 series terms), and a 32x32 multiplier is
// reused for series terms, the e^-i power loop and 20 log squarings. The
// result waits in an output register; the next beat is taken meanwhile. If
// that register is still full when the next result is ready, the block
// holds until it drains.
module stereo_log_envelope_follower_top #(
  parameter int MAX_BUFFER      = slef_pkg::MAX_BUFFER_DEF,
  parameter int LEVEL_FRAC_BITS = slef_pkg::LEVEL_FRAC_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // left_sample[31:0], right_sample[63:32]
  input  wire logic        in_tlast,   // end_of_buffer
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // log_left[22:0], log_right[45:23], zero pad
  input  wire logic        cfg_we,
  input  wire logic [slef_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [slef_pkg::COEF_W-1:0]    cfg_data
);
  localparam int F    = LEVEL_FRAC_BITS;
  localparam int CW   = $clog2(MAX_BUFFER + 1);
  localparam int SUMW = 31 + CW;
  localparam int LW   = 32 + F;
  localparam int NW   = SUMW + F + 1;
  localparam int DW   = (CW + 1 > 4) ? CW + 1 : 4;
  localparam int XW   = 17 + CW;
  localparam int IW   = XW - 16;
  localparam int PW   = $clog2(LW);
  localparam int LGW  = PW + slef_pkg::LOG_BITS + 2;
  localparam int OW   = slef_pkg::OUT_W;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_DIV_ST  = 5'd1;
  localparam logic [4:0] ST_DIV_WT  = 5'd2;
  localparam logic [4:0] ST_XMUL    = 5'd3;
  localparam logic [4:0] ST_XTAKE   = 5'd4;
  localparam logic [4:0] ST_EXP_INI = 5'd5;
  localparam logic [4:0] ST_EXP_MUL = 5'd6;
  localparam logic [4:0] ST_EXP_DVS = 5'd7;
  localparam logic [4:0] ST_EXP_DVW = 5'd8;
  localparam logic [4:0] ST_EXP_END = 5'd9;
  localparam logic [4:0] ST_POW_CHK = 5'd10;
  localparam logic [4:0] ST_POW_MUL = 5'd11;
  localparam logic [4:0] ST_POW_TK  = 5'd12;
  localparam logic [4:0] ST_MH_MUL  = 5'd13;
  localparam logic [4:0] ST_MH_TK   = 5'd14;
  localparam logic [4:0] ST_ML_TK   = 5'd15;
  localparam logic [4:0] ST_LN_ST   = 5'd16;
  localparam logic [4:0] ST_NORM    = 5'd17;
  localparam logic [4:0] ST_SQ_MUL  = 5'd18;
  localparam logic [4:0] ST_SQ_TK   = 5'd19;
  localparam logic [4:0] ST_LN_MUL  = 5'd20;
  localparam logic [4:0] ST_LN_TK   = 5'd21;
  localparam logic [4:0] ST_NEXT_CH = 5'd22;
  localparam logic [4:0] ST_FINISH  = 5'd23;

  logic [4:0] state_r, state_nxt;

  logic signed [slef_pkg::COEF_W-1:0] atk_r, rel_r;
  logic [SUMW-1:0] sum_lf_r, sum_lf_nxt, sum_rt_r, sum_rt_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt, n_r, n_nxt;
  logic [LW-1:0]   lvl_lf_r, lvl_lf_nxt, lvl_rt_r, lvl_rt_nxt;
  logic            ch_r, ch_nxt;
  logic            rise_r, rise_nxt;
  logic [LW-1:0]   tgt_r, tgt_nxt, d_r, d_nxt;
  logic [XW-1:0]   x_r, x_nxt;
  logic [30:0]     e1_r, e1_nxt, g_r, g_nxt, term_r, term_nxt, t_r, t_nxt;
  logic signed [32:0] acc_r, acc_nxt;
  logic [3:0]      k_r, k_nxt;
  logic            eph_r, eph_nxt;
  logic [IW-1:0]   i_r, i_nxt;
  logic [LW-1:0]   hi_r, hi_nxt, v_r, v_nxt;
  logic [PW-1:0]   p_r, p_nxt;
  logic [30:0]     m_r, m_nxt;
  logic [slef_pkg::LOG_BITS-1:0] bits_r, bits_nxt;
  logic [4:0]      j_r, j_nxt;
  logic [OW-1:0]   lg_lf_r, lg_lf_nxt, lg_rt_r, lg_rt_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;
  logic [47:0]     out_tdata_r, out_tdata_nxt;

  logic [31:0]     mul_a, mul_b;
  logic [63:0]     prod_r;

  logic            div_start, div_done;
  logic [NW-1:0]   div_num, div_quo;
  logic [DW-1:0]   div_den;

  logic [31:0]     mag_lf, mag_rt;
  logic [SUMW-1:0] sum_cur;
  logic [LW-1:0]   lvl_cur, lvl_new, mres;
  logic signed [slef_pkg::COEF_W-1:0] coef_sel;
  logic [16:0]     negc;
  logic [31:0]     mm;
  logic signed [LGW-1:0] l2;
  logic [LGW-1:0]  l2_mag;
  logic [63:0]     rnd;
  logic [OW-1:0]   lnv;
  logic signed [32:0] acc_cl;

  slef_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    mag_lf   = in_tdata[31] ? (~in_tdata[31:0] + 32'd1) : in_tdata[31:0];
    mag_rt   = in_tdata[63] ? (~in_tdata[63:32] + 32'd1) : in_tdata[63:32];
    sum_cur  = ch_r ? sum_rt_r : sum_lf_r;
    lvl_cur  = ch_r ? lvl_rt_r : lvl_lf_r;
    coef_sel = rise_r ? atk_r : rel_r;
    negc     = (coef_sel > 0) ? 17'd0 : 17'(-coef_sel);
    mm       = prod_r[61:30];
    mres     = hi_r + LW'(prod_r[59:30]);
    lvl_new  = rise_r ? (tgt_r - mres) : (tgt_r + mres);
    l2       = ((LGW'(p_r) - LGW'(F)) <<< slef_pkg::LOG_BITS) + LGW'(bits_r);
    l2_mag   = l2[LGW-1] ? LGW'(-l2) : LGW'(l2);
    rnd      = prod_r + (64'd1 << 33);
    lnv      = l2[LGW-1] ? OW'(-rnd[33+OW:34]) : rnd[33+OW:34];
    acc_cl   = acc_r;
    if (acc_r < 0) acc_cl = '0;
    else if (acc_r > 33'sd1073741824) acc_cl = 33'sd1073741824;
  end

  always_comb begin
    state_nxt      = state_r;
    sum_lf_nxt     = sum_lf_r;
    sum_rt_nxt     = sum_rt_r;
    cnt_nxt        = cnt_r;
    n_nxt          = n_r;
    lvl_lf_nxt     = lvl_lf_r;
    lvl_rt_nxt     = lvl_rt_r;
    ch_nxt         = ch_r;
    rise_nxt       = rise_r;
    tgt_nxt        = tgt_r;
    d_nxt          = d_r;
    x_nxt          = x_r;
    e1_nxt         = e1_r;
    g_nxt          = g_r;
    term_nxt       = term_r;
    t_nxt          = t_r;
    acc_nxt        = acc_r;
    k_nxt          = k_r;
    eph_nxt        = eph_r;
    i_nxt          = i_r;
    hi_nxt         = hi_r;
    v_nxt          = v_r;
    p_nxt          = p_r;
    m_nxt          = m_r;
    bits_nxt       = bits_r;
    j_nxt          = j_r;
    lg_lf_nxt      = lg_lf_r;
    lg_rt_nxt      = lg_rt_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    mul_a          = '0;
    mul_b          = '0;
    div_start      = 1'b0;
    div_num        = '0;
    div_den        = '0;
    in_tready      = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          n_nxt = cnt_r;
          if (cnt_r < CW'(MAX_BUFFER)) begin
            sum_lf_nxt = sum_lf_r + SUMW'(mag_lf);
            sum_rt_nxt = sum_rt_r + SUMW'(mag_rt);
            cnt_nxt    = cnt_r + 1'b1;
            n_nxt      = cnt_r + 1'b1;
          end
          if (in_tlast) begin
            ch_nxt    = 1'b0;
            state_nxt = ST_DIV_ST;
          end
        end
      end
      ST_DIV_ST: begin
        div_start = 1'b1;
        div_num   = NW'({sum_cur, {F{1'b0}}}) + NW'(lvl_cur);
        div_den   = DW'(n_r) + 1'b1;
        state_nxt = ST_DIV_WT;
      end
      ST_DIV_WT: begin
        if (div_done) begin
          tgt_nxt   = div_quo[LW-1:0];
          rise_nxt  = div_quo[LW-1:0] > lvl_cur;
          d_nxt     = (div_quo[LW-1:0] > lvl_cur) ? (div_quo[LW-1:0] - lvl_cur)
                                                  : (lvl_cur - div_quo[LW-1:0]);
          state_nxt = ST_XMUL;
        end
      end
      ST_XMUL: begin
        mul_a     = 32'(negc);
        mul_b     = 32'(n_r);
        state_nxt = ST_XTAKE;
      end
      ST_XTAKE: begin
        x_nxt     = prod_r[XW-1:0];
        eph_nxt   = 1'b0;
        state_nxt = ST_EXP_INI;
      end
      ST_EXP_INI: begin
        // e^-1 first, then e^-f
        term_nxt  = slef_pkg::ONE_Q30;
        acc_nxt   = 33'(slef_pkg::ONE_Q30);
        k_nxt     = 4'd1;
        t_nxt     = eph_r ? {1'b0, x_r[15:0], 14'd0} : slef_pkg::ONE_Q30;
        state_nxt = ST_EXP_MUL;
      end
      ST_EXP_MUL: begin
        mul_a     = 32'(term_r);
        mul_b     = 32'(t_r);
        state_nxt = ST_EXP_DVS;
      end
      ST_EXP_DVS: begin
        div_start = 1'b1;
        div_num   = NW'(prod_r[60:30]);
        div_den   = DW'(k_r);
        state_nxt = ST_EXP_DVW;
      end
      ST_EXP_DVW: begin
        if (div_done) begin
          term_nxt = div_quo[30:0];
          if (k_r[0]) acc_nxt = acc_r - $signed(33'(div_quo[30:0]));
          else        acc_nxt = acc_r + $signed(33'(div_quo[30:0]));
          if (k_r == 4'(slef_pkg::EXP_TERMS)) begin
            state_nxt = ST_EXP_END;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_EXP_MUL;
          end
        end
      end
      ST_EXP_END: begin
        if (!eph_r) begin
          e1_nxt    = acc_cl[30:0];
          eph_nxt   = 1'b1;
          state_nxt = ST_EXP_INI;
        end else begin
          g_nxt     = acc_cl[30:0];
          i_nxt     = x_r[XW-1:16];
          state_nxt = ST_POW_CHK;
        end
      end
      ST_POW_CHK: begin
        if (i_r == '0 || g_r == '0) state_nxt = ST_MH_MUL;
        else                        state_nxt = ST_POW_MUL;
      end
      ST_POW_MUL: begin
        mul_a     = 32'(g_r);
        mul_b     = 32'(e1_r);
        state_nxt = ST_POW_TK;
      end
      ST_POW_TK: begin
        g_nxt     = prod_r[60:30];
        i_nxt     = i_r - 1'b1;
        state_nxt = ST_POW_CHK;
      end
      ST_MH_MUL: begin
        mul_a     = 32'(g_r);
        mul_b     = 32'(d_r[LW-1:30]);
        state_nxt = ST_MH_TK;
      end
      ST_MH_TK: begin
        hi_nxt    = prod_r[LW-1:0];
        mul_a     = 32'(g_r);
        mul_b     = 32'(d_r[29:0]);
        state_nxt = ST_ML_TK;
      end
      ST_ML_TK: begin
        if (ch_r) lvl_rt_nxt = lvl_new;
        else      lvl_lf_nxt = lvl_new;
        state_nxt = ST_LN_ST;
      end
      ST_LN_ST: begin
        v_nxt = lvl_cur;
        p_nxt = PW'(LW - 1);
        if (lvl_cur == '0) begin
          if (ch_r) lg_rt_nxt = slef_pkg::LN_FLOOR;
          else      lg_lf_nxt = slef_pkg::LN_FLOOR;
          state_nxt = ST_NEXT_CH;
        end else begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        // shift until the top bit is set; p tracks its original position
        if (v_r[LW-1]) begin
          m_nxt     = v_r[LW-1 -: 31];
          j_nxt     = '0;
          bits_nxt  = '0;
          state_nxt = ST_SQ_MUL;
        end else begin
          v_nxt = {v_r[LW-2:0], 1'b0};
          p_nxt = p_r - 1'b1;
        end
      end
      ST_SQ_MUL: begin
        mul_a     = 32'(m_r);
        mul_b     = 32'(m_r);
        state_nxt = ST_SQ_TK;
      end
      ST_SQ_TK: begin
        bits_nxt = {bits_r[slef_pkg::LOG_BITS-2:0], mm[31]};
        m_nxt    = mm[31] ? mm[31:1] : mm[30:0];
        j_nxt    = j_r + 1'b1;
        if (j_r == 5'(slef_pkg::LOG_BITS - 1)) state_nxt = ST_LN_MUL;
        else                                   state_nxt = ST_SQ_MUL;
      end
      ST_LN_MUL: begin
        mul_a     = 32'(l2_mag);
        mul_b     = slef_pkg::LN2_Q30;
        state_nxt = ST_LN_TK;
      end
      ST_LN_TK: begin
        if (ch_r) lg_rt_nxt = lnv;
        else      lg_lf_nxt = lnv;
        state_nxt = ST_NEXT_CH;
      end
      ST_NEXT_CH: begin
        if (!ch_r) begin
          ch_nxt    = 1'b1;
          state_nxt = ST_DIV_ST;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tdata_nxt  = {2'b00, lg_rt_r, lg_lf_r};
          out_tvalid_nxt = 1'b1;
          sum_lf_nxt     = '0;
          sum_rt_nxt     = '0;
          cnt_nxt        = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      atk_r        <= slef_pkg::ATTACK_RST;
      rel_r        <= slef_pkg::RELEASE_RST;
      sum_lf_r     <= '0;
      sum_rt_r     <= '0;
      cnt_r        <= '0;
      lvl_lf_r     <= '0;
      lvl_rt_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sum_lf_r     <= sum_lf_nxt;
      sum_rt_r     <= sum_rt_nxt;
      cnt_r        <= cnt_nxt;
      lvl_lf_r     <= lvl_lf_nxt;
      lvl_rt_r     <= lvl_rt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          slef_pkg::REG_ATTACK:  atk_r <= $signed(cfg_data);
          slef_pkg::REG_RELEASE: rel_r <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
    n_r         <= n_nxt;
    ch_r        <= ch_nxt;
    rise_r      <= rise_nxt;
    tgt_r       <= tgt_nxt;
    d_r         <= d_nxt;
    x_r         <= x_nxt;
    e1_r        <= e1_nxt;
    g_r         <= g_nxt;
    term_r      <= term_nxt;
    t_r         <= t_nxt;
    acc_r       <= acc_nxt;
    k_r         <= k_nxt;
    eph_r       <= eph_nxt;
    i_r         <= i_nxt;
    hi_r        <= hi_nxt;
    v_r         <= v_nxt;
    p_r         <= p_nxt;
    m_r         <= m_nxt;
    bits_r      <= bits_nxt;
    j_r         <= j_nxt;
    lg_lf_r     <= lg_lf_nxt;
    lg_rt_r     <= lg_rt_nxt;
    out_tdata_r <= out_tdata_nxt;
    prod_r      <= mul_a * mul_b;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`include "stereo_log_envelope_follower_top_macros.svh"

  `SLEF_ASSERT_IMP(a_cnt_limit, 1'b1, cnt_r <= CW'(MAX_BUFFER), "sample count past limit")
  `SLEF_ASSERT_IMP(a_div_owner, div_done, state_r == ST_DIV_WT || state_r == ST_EXP_DVW, "divider done with no waiter")
  `SLEF_ASSERT_NXT(a_finish, state_r == ST_FINISH && (!out_tvalid_r || out_tready), out_tvalid_r && state_r == ST_IDLE && cnt_r == '0, "result not loaded")
  `SLEF_ASSERT_IMP(a_exp_k, state_r == ST_EXP_DVW, k_r != 4'd0 && k_r <= 4'(slef_pkg::EXP_TERMS), "series index out of range")
endmodule
`default_nettype wire
